// ===== rtl/fpr_pkg.sv =====
// Types and constants shared by the framed packet receiver.
`default_nettype none
package fpr_pkg;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;

  localparam logic [7:0]  StartByteReset = 8'd126;
  localparam logic [15:0] TimeoutReset   = 16'd1000;

  localparam int CfgDataWidth = 16;

  typedef enum logic {
    CFG_START_BYTE = 1'b0,
    CFG_TIMEOUT    = 1'b1
  } cfg_index_t;

  typedef enum logic [2:0] {
    KIND_PAYLOAD = 3'd0,
    KIND_GOOD    = 3'd1,
    KIND_CRC_ERR = 3'd2,
    KIND_LEN_ERR = 3'd3,
    KIND_TIMEOUT = 3'd4
  } kind_t;

  typedef struct packed {
    logic       is_tick;
    logic [7:0] rx_byte;
  } rx_req_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  frame_id;
    logic [7:0]  frame_length;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic [15:0] received_crc;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/fpr_if.sv =====
// Valid/ready channels for received requests and results.
`default_nettype none
interface fpr_rx_if import fpr_pkg::*; ;
  logic    valid;
  logic    ready;
  rx_req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface fpr_res_if import fpr_pkg::*; ;
  logic    valid;
  logic    ready;
  result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/fpr_crc16_step.sv =====
// One-byte parallel CRC-16/CCITT update, MSB first.
`default_nettype none
module fpr_crc16_step
  import fpr_pkg::*;
(
  input  logic [15:0] crc_in,
  input  logic [7:0]  data,
  output logic [15:0] crc_out
);

  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule
`default_nettype wire

// ===== rtl/framed_packet_receiver_crc16.sv =====
// Framed packet receiver: start-byte hunt, id, length, payload, CRC-16 check.
// Each request is one received byte or one time tick. The block takes one request every
// clock; the frame state and the result register update at the accepting edge, so a result
// appears in the cycle after its request, and the next request is taken while a result
// waits as long as the result is taken in the same cycle. The one-byte CRC update and the
// phase logic sit between the request port and the result register.
// A frame is the start byte, an id, a length of 1 to MAX_PAYLOAD, the payload bytes (each
// streamed out as a payload result) and a little-endian CRC-16/CCITT (init 0xFFFF, poly
// 0x1021) over start, id, length and payload. Frame good, CRC error, length error and
// timeout (more than timeout_ticks ticks since the last byte) end a frame.
`default_nettype none
module framed_packet_receiver_crc16
  import fpr_pkg::*;
#(
  parameter int MAX_PAYLOAD = 254
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  cfg_index_t              cfg_index,
  input  logic [CfgDataWidth-1:0] cfg_data,
  fpr_rx_if.sink                  rx,
  fpr_res_if.source               result
);

  localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD);

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_ID,
    PH_LEN,
    PH_PAYLOAD,
    PH_CRC
  } phase_t;

  logic [7:0]  start_byte;
  logic [15:0] timeout_ticks;

  phase_t      phase, phase_next;
  logic [7:0]  held_id, held_id_next;
  logic [7:0]  held_length, held_length_next;
  logic [7:0]  payload_count, payload_count_next;
  logic [15:0] running_crc, running_crc_next;
  logic [15:0] crc_from_frame, crc_from_frame_next;
  logic        crc_byte_count, crc_byte_count_next;
  logic [15:0] idle_ticks, idle_ticks_next;

  logic        out_valid;
  result_t     out_payload;
  logic        has_result;
  result_t     res;

  logic        accept;
  logic [15:0] crc_seed;
  logic [15:0] crc_upd;
  logic [15:0] crc_rx;
  logic [7:0]  b;

  assign rx.ready       = !out_valid || result.ready;
  assign accept         = rx.valid && rx.ready;
  assign result.valid   = out_valid;
  assign result.payload = out_payload;

  assign b        = rx.payload.rx_byte;
  assign crc_seed = (phase == PH_HUNT) ? CrcInit : running_crc;
  assign crc_rx   = {b, crc_from_frame[7:0]};

  fpr_crc16_step u_crc (
    .crc_in  (crc_seed),
    .data    (b),
    .crc_out (crc_upd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte    <= StartByteReset;
      timeout_ticks <= TimeoutReset;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_START_BYTE: start_byte    <= cfg_data[7:0];
        CFG_TIMEOUT:    timeout_ticks <= cfg_data[15:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    phase_next          = phase;
    held_id_next        = held_id;
    held_length_next    = held_length;
    payload_count_next  = payload_count;
    running_crc_next    = running_crc;
    crc_from_frame_next = crc_from_frame;
    crc_byte_count_next = crc_byte_count;
    idle_ticks_next     = idle_ticks;
    has_result          = 1'b0;
    res.kind            = KIND_PAYLOAD;
    res.frame_id        = held_id;
    res.frame_length    = held_length;
    res.payload_byte    = 8'd0;
    res.payload_index   = 8'd0;
    res.received_crc    = 16'd0;

    if (rx.payload.is_tick) begin
      if (phase != PH_HUNT) begin
        if (idle_ticks >= timeout_ticks) begin
          has_result          = 1'b1;
          res.kind            = KIND_TIMEOUT;
          phase_next          = PH_HUNT;
          held_id_next        = 8'd0;
          held_length_next    = 8'd0;
          payload_count_next  = 8'd0;
          running_crc_next    = CrcInit;
          crc_from_frame_next = 16'd0;
          crc_byte_count_next = 1'b0;
          idle_ticks_next     = 16'd0;
        end else begin
          idle_ticks_next = idle_ticks + 16'd1;
        end
      end
    end else begin
      idle_ticks_next = 16'd0;
      unique case (phase)
        PH_HUNT: begin
          if (b == start_byte) begin
            held_id_next        = 8'd0;
            held_length_next    = 8'd0;
            payload_count_next  = 8'd0;
            crc_from_frame_next = 16'd0;
            crc_byte_count_next = 1'b0;
            running_crc_next    = crc_upd;
            phase_next          = PH_ID;
          end
        end
        PH_ID: begin
          held_id_next     = b;
          running_crc_next = crc_upd;
          phase_next       = PH_LEN;
        end
        PH_LEN: begin
          if (b == 8'd0 || b > MaxLen) begin
            has_result          = 1'b1;
            res.kind            = KIND_LEN_ERR;
            res.frame_length    = b;
            phase_next          = PH_HUNT;
            held_id_next        = 8'd0;
            held_length_next    = 8'd0;
            payload_count_next  = 8'd0;
            running_crc_next    = CrcInit;
            crc_from_frame_next = 16'd0;
            crc_byte_count_next = 1'b0;
          end else begin
            held_length_next   = b;
            running_crc_next   = crc_upd;
            payload_count_next = 8'd0;
            phase_next         = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          has_result         = 1'b1;
          res.kind           = KIND_PAYLOAD;
          res.payload_byte   = b;
          res.payload_index  = payload_count;
          running_crc_next   = crc_upd;
          payload_count_next = payload_count + 8'd1;
          if (payload_count_next >= held_length) begin
            phase_next          = PH_CRC;
            crc_byte_count_next = 1'b0;
            crc_from_frame_next = 16'd0;
          end
        end
        PH_CRC: begin
          if (!crc_byte_count) begin
            crc_from_frame_next = {8'd0, b};
            crc_byte_count_next = 1'b1;
          end else begin
            has_result          = 1'b1;
            res.kind            = (crc_rx == running_crc) ? KIND_GOOD : KIND_CRC_ERR;
            res.received_crc    = crc_rx;
            phase_next          = PH_HUNT;
            held_id_next        = 8'd0;
            held_length_next    = 8'd0;
            payload_count_next  = 8'd0;
            running_crc_next    = CrcInit;
            crc_from_frame_next = 16'd0;
            crc_byte_count_next = 1'b0;
          end
        end
        default: begin
          phase_next = PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      held_id        <= 8'd0;
      held_length    <= 8'd0;
      payload_count  <= 8'd0;
      running_crc    <= CrcInit;
      crc_from_frame <= 16'd0;
      crc_byte_count <= 1'b0;
      idle_ticks     <= 16'd0;
      out_valid      <= 1'b0;
    end else if (accept) begin
      phase          <= phase_next;
      held_id        <= held_id_next;
      held_length    <= held_length_next;
      payload_count  <= payload_count_next;
      running_crc    <= running_crc_next;
      crc_from_frame <= crc_from_frame_next;
      crc_byte_count <= crc_byte_count_next;
      idle_ticks     <= idle_ticks_next;
      out_valid      <= has_result;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && has_result) begin
      out_payload <= res;
    end
  end

  a_hunt_no_idle: assert property (@(posedge clk) disable iff (rst)
    phase == PH_HUNT |-> idle_ticks == 16'd0)
    else $error("idle tick count running outside a frame");

  a_payload_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> payload_count < held_length)
    else $error("payload count past frame length");

  a_length_range: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAYLOAD || phase == PH_CRC) |-> (held_length != 8'd0 && held_length <= MaxLen))
    else $error("open frame holds a bad length");

  a_hunt_tick_silent: assert property (@(posedge clk) disable iff (rst)
    (accept && rx.payload.is_tick && phase == PH_HUNT) |=> !result.valid)
    else $error("result from a tick while hunting");

endmodule
`default_nettype wire
